FILE: rtl/morse_lamp_keyer_defines.svh
// Assertion macros shared by the keyer RTL.
// Used by morse_lamp_keyer, which carries the concurrent checks; depends on nothing else.
`ifndef MORSE_LAMP_KEYER_DEFINES_SVH
`define MORSE_LAMP_KEYER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLK_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mlk_pkg.sv
// Shared types, constants and the Morse code table for the lamp keyer.
// Used by mlk_step and morse_lamp_keyer; depends on nothing.
package mlk_pkg;

  localparam int unsigned MAX_CHARS_DEF = 64;
  localparam int unsigned DOT_W         = 16;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned ELEM_W        = 3;
  localparam int unsigned TICK_W        = 20;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned IDX_W         = 6;

  localparam logic [TICK_W-1:0] ELAPSED_MAX   = '1;
  localparam logic [DOT_W-1:0]  DOT_RESET     = 16'd100;
  localparam logic [LEN_W-1:0]  MSG_LEN_RESET = 7'd1;

  // Item kinds carried in the input tuser bit.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_DOT_LENGTH     = 1'b0;
  localparam logic REG_MESSAGE_LENGTH = 1'b1;

  // Keyer state kept in flip-flops next to the message memory.
  typedef struct packed {
    logic              lamp;
    logic [ELEM_W-1:0] elem;
    logic [TICK_W-1:0] elapsed;
    logic [TICK_W-1:0] interval;
  } keyer_state_t;

  // One letter: number of elements, and a dash flag per element (bit 0 first).
  typedef struct packed {
    logic [2:0] len;
    logic [3:0] dash;
  } code_t;

  function automatic code_t code_lookup(input logic [CHAR_W-1:0] ch);
    code_t c;
    c = '{len: 3'd0, dash: 4'b0000};
    case (ch)
      "A": c = '{len: 3'd2, dash: 4'b0010};
      "B": c = '{len: 3'd4, dash: 4'b0001};
      "C": c = '{len: 3'd4, dash: 4'b0101};
      "D": c = '{len: 3'd3, dash: 4'b0001};
      "E": c = '{len: 3'd1, dash: 4'b0000};
      "F": c = '{len: 3'd4, dash: 4'b0100};
      "G": c = '{len: 3'd3, dash: 4'b0011};
      "H": c = '{len: 3'd4, dash: 4'b0000};
      "I": c = '{len: 3'd2, dash: 4'b0000};
      "J": c = '{len: 3'd4, dash: 4'b1110};
      "K": c = '{len: 3'd3, dash: 4'b0101};
      "L": c = '{len: 3'd4, dash: 4'b0010};
      "M": c = '{len: 3'd2, dash: 4'b0011};
      "N": c = '{len: 3'd2, dash: 4'b0001};
      "O": c = '{len: 3'd3, dash: 4'b0111};
      "P": c = '{len: 3'd4, dash: 4'b0110};
      "Q": c = '{len: 3'd4, dash: 4'b1011};
      "R": c = '{len: 3'd3, dash: 4'b0010};
      "S": c = '{len: 3'd3, dash: 4'b0000};
      "T": c = '{len: 3'd1, dash: 4'b0001};
      "U": c = '{len: 3'd3, dash: 4'b0100};
      "V": c = '{len: 3'd4, dash: 4'b1000};
      "W": c = '{len: 3'd3, dash: 4'b0110};
      "X": c = '{len: 3'd4, dash: 4'b1001};
      "Y": c = '{len: 3'd4, dash: 4'b1101};
      "Z": c = '{len: 3'd4, dash: 4'b0011};
      default: c = '{len: 3'd0, dash: 4'b0000};
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/mlk_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a collision; no reset on the array. Depends on nothing.
module mlk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mlk_step.sv
// Next-state logic of the keyer for one transaction: tick count, lamp
// toggling, element and letter stepping. Depends on mlk_pkg.
module mlk_step #(
  parameter int unsigned MAX_CHARS = mlk_pkg::MAX_CHARS_DEF,
  localparam int unsigned LW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
  input  logic                          kind_i,
  input  logic [mlk_pkg::CHAR_W-1:0]    cur_char_i,
  input  mlk_pkg::keyer_state_t         st_i,
  input  logic [LW-1:0]                 letter_i,
  input  logic [mlk_pkg::DOT_W-1:0]     dot_i,
  input  logic [mlk_pkg::LEN_W-1:0]     msg_len_i,
  output mlk_pkg::keyer_state_t         st_o,
  output logic [LW-1:0]                 letter_o,
  output logic                          toggled_o
);

  localparam int unsigned CW = (LW + 1 > mlk_pkg::LEN_W) ? LW + 1 : mlk_pkg::LEN_W;

  mlk_pkg::code_t            code;
  logic [mlk_pkg::TICK_W-1:0] dot_x;
  logic [mlk_pkg::TICK_W-1:0] dot1;
  logic [mlk_pkg::TICK_W-1:0] dot3;
  logic [mlk_pkg::TICK_W-1:0] dot7;
  logic [CW-1:0]              eff_len;
  logic [LW:0]                letter_w;

  assign code  = mlk_pkg::code_lookup(cur_char_i);
  assign dot_x = mlk_pkg::TICK_W'(dot_i);
  assign dot1  = dot_x;
  assign dot3  = (dot_x << 1) + dot_x;
  assign dot7  = (dot_x << 3) - dot_x;
  assign eff_len = (CW'(msg_len_i) > CW'(MAX_CHARS)) ? CW'(MAX_CHARS) : CW'(msg_len_i);

  always_comb begin
    st_o      = st_i;
    letter_w  = {1'b0, letter_i};
    toggled_o = 1'b0;
    if (kind_i == mlk_pkg::KIND_TICK) begin
      if (st_i.elapsed != mlk_pkg::ELAPSED_MAX) begin
        st_o.elapsed = st_i.elapsed + 1'b1;
      end
      if (st_o.elapsed >= st_i.interval) begin
        st_o.elapsed = '0;
        if (!st_i.lamp && (st_i.elem >= code.len)) begin
          // Nothing left to light in this letter: stay dark.
          st_o.elem = code.len;
        end else begin
          toggled_o = 1'b1;
          st_o.lamp = !st_i.lamp;
          if (!st_o.lamp) begin
            st_o.elem     = st_i.elem + 1'b1;
            st_o.interval = dot1;
          end else if (code.dash[st_i.elem[1:0]]) begin
            st_o.interval = dot3;
          end else begin
            st_o.interval = dot1;
          end
        end
        if (st_o.elem >= code.len) begin
          st_o.elem     = '0;
          letter_w      = letter_w + 1'b1;
          st_o.interval = dot3;
        end
        if (CW'(letter_w) >= eff_len) begin
          letter_w      = '0;
          st_o.interval = dot7;
        end
      end
    end
  end

  assign letter_o = letter_w[LW-1:0];

endmodule

FILE: rtl/morse_lamp_keyer.sv
// Top level of the looping Morse lamp keyer: handshakes, configuration,
// keyer registers, message memory with write forwarding, and result register.
// Depends on mlk_pkg, mlk_ram, mlk_step and morse_lamp_keyer_defines.svh.

// The keyer takes one transaction per clock cycle while results are taken, and
// returns exactly one result for each in the cycle after acceptance through a
// registered output; a stalled output holds only the slot that is full, and
// the input keeps flowing while the downstream side takes results. A tick
// transaction (tuser low) advances the timing; a write transaction (tuser
// high) stores one character into the message memory, and positions at or
// above MAX_CHARS are ignored. The message lives in a registered-read RAM that
// is always read at the letter index the keyer will hold after the current
// cycle, so the character to be keyed is ready at the next transaction; a
// write to that same position in the same cycle is forwarded around the RAM.
// Reads of positions never written return undefined characters. There is no
// clearing pass: the input is ready in the cycle after reset is released.
// Configuration writes take effect at once and are meant for idle periods.
`include "morse_lamp_keyer_defines.svh"

module morse_lamp_keyer #(
  parameter int unsigned MAX_CHARS = mlk_pkg::MAX_CHARS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic                       cfg_addr_i,
  input  logic [mlk_pkg::DOT_W-1:0]  cfg_wdata_i,
  // Input stream.
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata from bit 0: char_index[5:0], char_value[13:6], zero pad [15:14].
  input  logic [15:0]                s_axis_tdata_i,
  // tuser: kind (0 = tick, 1 = write character).
  input  logic                       s_axis_tuser_i,
  // Result stream.
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // tdata from bit 0: lamp_on[0], letter_position[6:1], toggled[7].
  output logic [7:0]                 m_axis_tdata_o
);

  localparam int unsigned LW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  // Configuration registers.
  logic [mlk_pkg::DOT_W-1:0] dot_q;
  logic [mlk_pkg::LEN_W-1:0] msg_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q     <= mlk_pkg::DOT_RESET;
      msg_len_q <= mlk_pkg::MSG_LEN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == mlk_pkg::REG_DOT_LENGTH) begin
        dot_q <= cfg_wdata_i;
      end else if (cfg_addr_i == mlk_pkg::REG_MESSAGE_LENGTH) begin
        msg_len_q <= cfg_wdata_i[mlk_pkg::LEN_W-1:0];
      end
    end
  end

  // Input decode and handshake. The ready flag holds the input off after reset
  // until it is registered high, so the memory read at letter zero is settled.
  logic                        ready_q;
  logic                        out_valid_q;
  logic                        accept;
  logic                        kind;
  logic [mlk_pkg::IDX_W-1:0]   char_index;
  logic [mlk_pkg::CHAR_W-1:0]  char_value;

  assign kind       = s_axis_tuser_i;
  assign char_index = s_axis_tdata_i[5:0];
  assign char_value = s_axis_tdata_i[13:6];

  assign s_axis_tready_o = ready_q && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Keyer registers.
  mlk_pkg::keyer_state_t st_q, st_d, st_next;
  logic [LW-1:0]         letter_q, letter_d, letter_next;
  logic                  toggled;

  // Message memory with forwarding of a same-cycle write to the read address.
  logic                       wr_en;
  logic [LW-1:0]              waddr;
  logic [mlk_pkg::CHAR_W-1:0] ram_rdata;
  logic                       fwd_valid_q;
  logic [mlk_pkg::CHAR_W-1:0] fwd_data_q;
  logic [mlk_pkg::CHAR_W-1:0] cur_char;

  assign wr_en = accept && (kind == mlk_pkg::KIND_WRITE) &&
                 (32'(char_index) < 32'(MAX_CHARS));
  assign waddr = LW'(char_index);

  mlk_ram #(
    .WIDTH (mlk_pkg::CHAR_W),
    .DEPTH (MAX_CHARS)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (char_value),
    .raddr_i (letter_d),
    .rdata_o (ram_rdata)
  );

  assign cur_char = fwd_valid_q ? fwd_data_q : ram_rdata;

  mlk_step #(
    .MAX_CHARS (MAX_CHARS)
  ) u_step (
    .kind_i     (kind),
    .cur_char_i (cur_char),
    .st_i       (st_q),
    .letter_i   (letter_q),
    .dot_i      (dot_q),
    .msg_len_i  (msg_len_q),
    .st_o       (st_next),
    .letter_o   (letter_next),
    .toggled_o  (toggled)
  );

  assign st_d     = accept ? st_next : st_q;
  assign letter_d = accept ? letter_next : letter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= 1'b0;
      st_q        <= '0;
      letter_q    <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      ready_q     <= 1'b1;
      st_q        <= st_d;
      letter_q    <= letter_d;
      fwd_valid_q <= wr_en && (waddr == letter_d);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= char_value;
  end

  // Result register.
  logic                       out_lamp_q;
  logic [mlk_pkg::IDX_W-1:0]  out_pos_q;
  logic                       out_toggled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_lamp_q    <= st_next.lamp;
      out_pos_q     <= mlk_pkg::IDX_W'(letter_next);
      out_toggled_q <= toggled;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_toggled_q, out_pos_q, out_lamp_q};

  // A toggle flag in a result must match an actual change of the lamp.
  `MLK_ASSERT_NXT(a_toggle_matches_lamp, clk_i, rst_ni,
    accept && (kind == mlk_pkg::KIND_TICK),
    out_toggled_q == (st_q.lamp != $past(st_q.lamp)), "toggle flag disagrees with lamp")
  // A character write never moves the lamp.
  `MLK_ASSERT_NXT(a_write_keeps_lamp, clk_i, rst_ni,
    accept && (kind == mlk_pkg::KIND_WRITE),
    !out_toggled_q && (st_q.lamp == $past(st_q.lamp)), "write item changed the lamp")
  // The tick counter is cleared whenever it reaches the interval.
  `MLK_ASSERT_IMP(a_elapsed_in_interval, clk_i, rst_ni,
    ready_q, st_q.elapsed <= st_q.interval, "elapsed count ran past the interval")
  // Every accepted transaction leaves a result in the output register.
  `MLK_ASSERT_NXT(a_result_follows, clk_i, rst_ni,
    accept, out_valid_q, "accepted transaction produced no result")

endmodule
